// ----- rtl/bouncing_triangle_trail_assert.svh -----
// Assertion macros used by the checker file.
// Clocked by clk; the plain form is disabled while rst is high.
`ifndef BOUNCING_TRIANGLE_TRAIL_ASSERT_SVH
`define BOUNCING_TRIANGLE_TRAIL_ASSERT_SVH

// Concurrent check, disabled during reset.
`define BTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds while reset is applied.
`define BTT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/btt_pkg.sv -----
// Types, constants and the bounce function for the triangle trail.
// No dependencies.
`default_nettype none

package btt_pkg;

  localparam int HISTORY = 150;
  localparam int SLOT_W  = $clog2(HISTORY);
  localparam int COORD_W = 11;

  localparam int SEGS_PER_TRI = 3;
  localparam logic [2:0] LAST_SEG = 3'd5;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [3:0]  vel_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef point_t [SEGS_PER_TRI-1:0] tri_t;

  typedef struct packed {
    vel_t dx;
    vel_t dy;
  } vel_pair_t;

  typedef vel_pair_t [SEGS_PER_TRI-1:0] vel_tri_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_CORNER_X = 2'd2,
    REG_CORNER_Y = 2'd3
  } reg_idx_t;

  localparam coord_t ORIGIN_X_RST = 11'd0;
  localparam coord_t ORIGIN_Y_RST = 11'd0;
  localparam coord_t CORNER_X_RST = 11'd799;
  localparam coord_t CORNER_Y_RST = 11'd1023;

  localparam vel_tri_t VEL_INIT = '{
    2: '{dx: 4'sd2,  dy: 4'sd1},
    1: '{dx: -4'sd4, dy: 4'sd3},
    0: '{dx: 4'sd3,  dy: -4'sd2}
  };

  typedef struct packed {
    coord_t v;
    vel_t   d;
  } bounce_t;

  // One axis step: reflect at the rectangle edges, then clamp to the field range.
  function automatic bounce_t bounce(input coord_t p, input vel_t d,
                                     input coord_t lo, input coord_t hi);
    logic signed [12:0] pe;
    logic signed [12:0] de;
    logic signed [12:0] v;
    logic signed [12:0] r;
    logic               hit;
    bounce_t            res;
    pe  = $signed({2'b00, p});
    de  = $signed({{9{d[3]}}, d});
    v   = pe + de;
    hit = (v > $signed({2'b00, hi})) || (v < $signed({2'b00, lo}));
    r   = hit ? (pe - de) : v;
    res.d = hit ? -d : d;
    if (r < 13'sd0) begin
      res.v = '0;
    end else if (r > 13'sd2047) begin
      res.v = '1;
    end else begin
      res.v = r[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/btt_if.sv -----
// Valid/ready channel interfaces: tick requests in, segments out.
// Uses btt_pkg for the coordinate type.
`default_nettype none

interface btt_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface btt_seg_if;
  import btt_pkg::*;
  logic   valid;
  logic   ready;
  coord_t seg_x0;
  coord_t seg_y0;
  coord_t seg_x1;
  coord_t seg_y1;
  logic   is_draw;
  logic   last;
  modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                  output seg_y1, output is_draw, output last, input ready);
  modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                  input seg_y1, input is_draw, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/btt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module btt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and write at one address return the old word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bouncing_triangle_trail.sv -----
// Bouncing triangle trail: ring of triangles, six XOR segments per tick item.
// An accepted tick waits in the pending register, so one new tick can be taken
// while the prior one is emitted; one segment per cycle while seg.ready is high.
// A tick with value 0 is accepted and yields nothing.
// Reset: slot 0, initial velocities, rectangle defaults; all ring slots read
// as the origin (0,0) until written, tracked by one valid flop per slot.
`default_nettype none

module bouncing_triangle_trail
  import btt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [10:0]  cfg_data,
  btt_tick_if.sink          req,
  btt_seg_if.source         seg
);

  // rectangle registers
  coord_t origin_x, origin_y, corner_x, corner_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= ORIGIN_X_RST;
      origin_y <= ORIGIN_Y_RST;
      corner_x <= CORNER_X_RST;
      corner_y <= CORNER_Y_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_CORNER_X: corner_x <= cfg_data;
        REG_CORNER_Y: corner_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // step state
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  cur;
  logic [HISTORY-1:0] slot_valid;
  tri_t               newest;
  vel_tri_t           vel;
  tri_t               moved;
  vel_tri_t           vel_next;

  // pending job: erase triangle sits in the RAM read register
  logic     pend_valid;
  logic     erase_vld;
  tri_t     draw_pend;
  tri_t     ram_q;
  tri_t     erase_pend;

  // segment emitter
  logic       out_valid;
  logic [2:0] count;
  tri_t       tri_e;
  tri_t       tri_d;

  logic accept, act, load_now;

  assign load_now  = pend_valid && (!out_valid || (seg.ready && count == LAST_SEG));
  assign req.ready = !pend_valid || load_now;
  assign accept    = req.valid && req.ready;
  assign act       = accept && req.tick;

  assign cur = (slot == SLOT_W'(HISTORY - 1)) ? '0 : slot + 1'b1;

  always_comb begin
    bounce_t bx;
    bounce_t by;
    for (int i = 0; i < SEGS_PER_TRI; i++) begin
      bx = bounce(newest[i].x, vel[i].dx, origin_x, corner_x);
      by = bounce(newest[i].y, vel[i].dy, origin_y, corner_y);
      moved[i].x       = bx.v;
      moved[i].y       = by.v;
      vel_next[i].dx   = bx.d;
      vel_next[i].dy   = by.d;
    end
  end

  btt_ram #(
    .WIDTH ($bits(tri_t)),
    .DEPTH (HISTORY)
  ) u_ring (
    .clk     (clk),
    .we      (act),
    .wr_addr (cur),
    .wr_data (moved),
    .rd_en   (act),
    .rd_addr (cur),
    .rd_data (ram_q)
  );

  assign erase_pend = erase_vld ? ram_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      slot_valid <= '0;
      newest     <= '0;
      vel        <= VEL_INIT;
      pend_valid <= 1'b0;
    end else begin
      if (act) begin
        slot            <= cur;
        slot_valid[cur] <= 1'b1;
        newest          <= moved;
        vel             <= vel_next;
        pend_valid      <= 1'b1;
      end else if (load_now) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      erase_vld <= slot_valid[cur];
      draw_pend <= moved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else if (load_now) begin
      out_valid <= 1'b1;
      count     <= '0;
      tri_e     <= erase_pend;
      tri_d     <= draw_pend;
    end else if (out_valid && seg.ready) begin
      if (count == LAST_SEG) begin
        out_valid <= 1'b0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // edges: (first,second), (second,third), (third,first)
  logic       draw_half;
  logic [1:0] ea, eb;
  tri_t       tsel;

  assign draw_half = (count >= 3'(SEGS_PER_TRI));
  assign ea        = draw_half ? 2'(count - 3'(SEGS_PER_TRI)) : count[1:0];
  assign eb        = (ea == 2'(SEGS_PER_TRI - 1)) ? 2'd0 : ea + 1'b1;
  assign tsel      = draw_half ? tri_d : tri_e;

  assign seg.valid   = out_valid;
  assign seg.seg_x0  = tsel[ea].x;
  assign seg.seg_y0  = tsel[ea].y;
  assign seg.seg_x1  = tsel[eb].x;
  assign seg.seg_y1  = tsel[eb].y;
  assign seg.is_draw = draw_half;
  assign seg.last    = (count == LAST_SEG);

endmodule

`default_nettype wire

// ----- rtl/btt_checker.sv -----
// Port-level checks on the segment output of the triangle trail.
// Uses bouncing_triangle_trail_assert.svh and btt_pkg; bound to the top level.
`default_nettype none
`include "bouncing_triangle_trail_assert.svh"

module btt_checker
  import btt_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   seg_valid,
  input wire logic   seg_ready,
  input wire coord_t seg_x0,
  input wire coord_t seg_y0,
  input wire coord_t seg_x1,
  input wire coord_t seg_y1,
  input wire logic   seg_is_draw,
  input wire logic   seg_last
);

  `BTT_ASSERT_RST(a_rst_idle, rst |=> !seg_valid, "segment valid right after reset")

  `BTT_ASSERT(a_hold, seg_valid && !seg_ready |=> seg_valid && $stable(seg_x0) && $stable(seg_y0) && $stable(seg_x1) && $stable(seg_y1) && $stable(seg_is_draw) && $stable(seg_last), "stalled segment changed")

  `BTT_ASSERT(a_last_draw, seg_valid && seg_last |-> seg_is_draw, "final segment is not a draw edge")

  `BTT_ASSERT(a_burst, seg_valid && seg_ready && !seg_last |=> seg_valid, "gap inside a tick's segments")

endmodule

bind bouncing_triangle_trail btt_checker u_btt_checker (
  .clk         (clk),
  .rst         (rst),
  .seg_valid   (seg.valid),
  .seg_ready   (seg.ready),
  .seg_x0      (seg.seg_x0),
  .seg_y0      (seg.seg_y0),
  .seg_x1      (seg.seg_x1),
  .seg_y1      (seg.seg_y1),
  .seg_is_draw (seg.is_draw),
  .seg_last    (seg.last)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bouncing_triangle_trail: tick items in, six segments out.
// Depends on btt_pkg and the channel interfaces in btt_if.sv.

module tb_top;
  import btt_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int COORD_TOP     = 2047;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   is_draw;
    logic   last;
  } segment_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  btt_tick_if req_ch();
  btt_seg_if  seg_ch();

  bouncing_triangle_trail uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .seg       (seg_ch)
  );

  // Trail mirror: newest triangle sits at slot, corners in edge order.
  point_t   trail [HISTORY][3];
  vel_t     speed [3][2];
  int       slot;
  coord_t   box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  segment_t segs_due[$];

  bit steady;
  int errors, n_ticks, n_zero, n_segs, n_writes, quiet_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic reset_trail();
    for (int s = 0; s < HISTORY; s++) begin
      for (int c = 0; c < 3; c++) begin
        trail[s][c] = '0;
      end
    end
    speed[0][0] = 3;
    speed[0][1] = -2;
    speed[1][0] = -4;
    speed[1][1] = 3;
    speed[2][0] = 2;
    speed[2][1] = 1;
    slot     = 0;
    box_lo_x = 0;
    box_lo_y = 0;
    box_hi_x = 799;
    box_hi_y = 1023;
  endtask

  // Advance the trail one step and queue the six segments it produces.
  task automatic predict_segments();
    int       prev, cur, p, d, lo, hi, v;
    point_t   shape [2][3];
    point_t   a, b;
    segment_t s;
    prev = slot;
    cur  = (prev + 1 == HISTORY) ? 0 : prev + 1;
    slot = cur;
    for (int c = 0; c < 3; c++) begin
      shape[0][c] = trail[cur][c];
    end
    for (int c = 0; c < 3; c++) begin
      for (int ax = 0; ax < 2; ax++) begin
        p  = ax ? trail[prev][c].y : trail[prev][c].x;
        d  = speed[c][ax];
        lo = ax ? box_lo_y : box_lo_x;
        hi = ax ? box_hi_y : box_hi_x;
        v  = p + d;
        if (v > hi || v < lo) begin
          d = -d;
          v = v + 2 * d;
        end
        if (v < 0) begin
          v = 0;
        end else if (v > COORD_TOP) begin
          v = COORD_TOP;
        end
        speed[c][ax] = d;
        if (ax) begin
          shape[1][c].y = v;
        end else begin
          shape[1][c].x = v;
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      trail[cur][c] = shape[1][c];
    end
    // erase edges of the overwritten triangle, then draw edges of the new one
    for (int k = 0; k < 6; k++) begin
      a = shape[k / 3][k % 3];
      b = shape[k / 3][(k % 3 + 1) % 3];
      s.x0      = a.x;
      s.y0      = a.y;
      s.x1      = b.x;
      s.y1      = b.y;
      s.is_draw = (k >= 3);
      s.last    = (k == 5);
      segs_due.push_back(s);
    end
  endtask

  // Input monitor first, then output check, so ordering within a step is fixed.
  always @(posedge clk) begin
    segment_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.tick) begin
          n_ticks++;
          predict_segments();
        end else begin
          n_zero++;
        end
      end
      if (seg_ch.valid && seg_ch.ready) begin
        n_segs++;
        if (segs_due.size() == 0) begin
          report_mismatch("segment with nothing due", 1, 0);
        end else begin
          want = segs_due.pop_front();
          if (seg_ch.seg_x0 !== want.x0) report_mismatch("seg_x0", seg_ch.seg_x0, want.x0);
          if (seg_ch.seg_y0 !== want.y0) report_mismatch("seg_y0", seg_ch.seg_y0, want.y0);
          if (seg_ch.seg_x1 !== want.x1) report_mismatch("seg_x1", seg_ch.seg_x1, want.x1);
          if (seg_ch.seg_y1 !== want.y1) report_mismatch("seg_y1", seg_ch.seg_y1, want.y1);
          if (seg_ch.is_draw !== want.is_draw) begin
            report_mismatch("is_draw", seg_ch.is_draw, want.is_draw);
          end
          if (seg_ch.last !== want.last) report_mismatch("last", seg_ch.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      seg_ch.ready <= 1'b0;
    end else begin
      seg_ch.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (seg_ch.valid && seg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("[bouncing_triangle_trail] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic t);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.tick  <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain_segments();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (segs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[10:0];
    case (idx)
      REG_ORIGIN_X: box_lo_x = val[10:0];
      REG_ORIGIN_Y: box_lo_y = val[10:0];
      REG_CORNER_X: box_hi_x = val[10:0];
      REG_CORNER_Y: box_hi_y = val[10:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_box(input int ox, input int oy, input int cx, input int cy);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CORNER_X, cx);
    write_reg(REG_CORNER_Y, cy);
  endtask

  task automatic test_power_on_defaults();
    steady = 1'b1;
    repeat (5) send_tick(1'b1);
    steady = 1'b0;
  endtask

  task automatic test_ignored_ticks();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_degenerate_boxes();
    // box collapsed onto the field origin
    drain_segments();
    write_box(0, 0, 0, 0);
    repeat (3) send_tick(1'b1);
    // collapsed box far from the trail: every step reflects
    drain_segments();
    write_box(1024, 1024, 1024, 1024);
    repeat (2) send_tick(1'b1);
    // inverted box, reflections near zero clamp low
    drain_segments();
    write_box(1500, 1800, 20, 30);
    repeat (4) send_tick(1'b1);
  endtask

  task automatic pick_random_box();
    int lx, ly, hx, hy;
    case ($urandom_range(3))
      0: begin
        lx = 0;
        ly = 0;
        hx = COORD_TOP;
        hy = COORD_TOP;
      end
      1: begin
        lx = $urandom_range(0, 1200);
        ly = $urandom_range(0, 1200);
        hx = lx + $urandom_range(100, 847);
        hy = ly + $urandom_range(100, 847);
      end
      2: begin
        // unordered, often inverted
        lx = $urandom_range(0, COORD_TOP);
        ly = $urandom_range(0, COORD_TOP);
        hx = $urandom_range(0, COORD_TOP);
        hy = $urandom_range(0, COORD_TOP);
      end
      default: begin
        lx = $urandom_range(0, COORD_TOP);
        ly = $urandom_range(0, COORD_TOP);
        hx = lx + $urandom_range(0, 6);
        hy = ly + $urandom_range(0, 6);
        if (hx > COORD_TOP) hx = COORD_TOP;
        if (hy > COORD_TOP) hy = COORD_TOP;
      end
    endcase
    write_box(lx, ly, hx, hy);
  endtask

  task automatic test_random_traffic();
    int sent;
    for (int phase = 0; phase < 6; phase++) begin
      drain_segments();
      pick_random_box();
      steady = (phase == 2);
      sent = 0;
      while (sent < 31) begin
        if ($urandom_range(99) < 12) begin
          send_tick(1'b0);
        end else begin
          send_tick(1'b1);
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.tick  = 1'b0;
    steady       = 1'b0;
    errors       = 0;
    n_ticks      = 0;
    n_zero       = 0;
    n_segs       = 0;
    n_writes     = 0;
    reset_trail();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_power_on_defaults();
    test_ignored_ticks();
    test_degenerate_boxes();
    test_random_traffic();
    drain_segments();

    if (segs_due.size() != 0) report_mismatch("segments still due", segs_due.size(), 0);
    $display("covered %0d ticks and %0d zero ticks, %0d segments checked",
             n_ticks, n_zero, n_segs);
    $display("%0d register writes, ring wrapped %0d times", n_writes, n_ticks / HISTORY);
    if (errors == 0) begin
      $display("[bouncing_triangle_trail] OK");
    end else begin
      $display("[bouncing_triangle_trail] ERROR");
    end
    $finish;
  end

endmodule
